// File: hdl/assert_macros.svh
// Assertion macros shared by the frame bus writer RTL.
// Depends on nothing; included by every file that carries assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define ASSERT_CLK(name, clk, rst_n, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// Checks that a condition never holds outside reset.
`define ASSERT_NEVER(name, clk, rst_n, cond, msg) \
	name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error(msg);

`endif

// File: hdl/lcdfw_pkg.sv
// Types and constants of the LCD frame bus writer.
// Depends on nothing; imported by lcdfw_byte_ser and the top level.
package lcdfw_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd0;
	localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd1;

	// Panel register indexes written at the start of each row.
	localparam logic [15:0] PANEL_REG_GRAM_X    = 16'h0020;
	localparam logic [15:0] PANEL_REG_GRAM_Y    = 16'h0021;
	localparam logic [15:0] PANEL_REG_GRAM_DATA = 16'h0022;
	localparam logic [15:0] GRAM_X_START        = 16'h0000;

	// Word slots of the byte sequence for one pixel.
	localparam logic [2:0] SLOT_X_INDEX    = 3'd0;
	localparam logic [2:0] SLOT_X_DATA     = 3'd1;
	localparam logic [2:0] SLOT_Y_INDEX    = 3'd2;
	localparam logic [2:0] SLOT_Y_DATA     = 3'd3;
	localparam logic [2:0] SLOT_GRAM_INDEX = 3'd4;
	localparam logic [2:0] SLOT_COLOUR     = 3'd5;

	// Byte positions within the twelve-byte row-start sequence.
	localparam logic [3:0] BYTE_FIRST     = 4'd0;
	localparam logic [3:0] BYTE_COLOUR_HI = 4'd10;
	localparam logic [3:0] BYTE_LAST      = 4'd11;

	// Register-select levels on the panel bus.
	localparam logic RS_INDEX = 1'b0;
	localparam logic RS_DATA  = 1'b1;

	// One pixel request handed to the byte serialiser.
	typedef struct packed {
		logic [15:0] colour;
		logic [15:0] row;
		logic        row_start;
		logic        frame_end;
	} pix_item_t;

endpackage

// File: hdl/lcdfw_byte_ser.sv
// Byte serialiser of the LCD frame bus writer: turns one pixel request into bus bytes.
// Depends on lcdfw_pkg and assert_macros.svh.
`include "assert_macros.svh"

module lcdfw_byte_ser
	import lcdfw_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_ready,
	input  pix_item_t  item,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       out_rs,
	output logic       out_last,
	output logic       out_frame_done
);

	pix_item_t   item_q;
	logic [3:0]  idx_q;
	logic        busy_q;
	logic        out_valid_q;
	logic [7:0]  byte_q;
	logic        rs_q;
	logic        last_q;
	logic        done_q;

	logic        out_free;
	logic        emit;
	logic        load;
	logic [15:0] word;
	logic        word_rs;
	logic        at_last;

	// The output register is free when empty or when its byte is taken now.
	assign out_free   = !out_valid_q || out_ready;
	assign emit       = busy_q && out_free;
	assign at_last    = (idx_q == BYTE_LAST);
	assign item_ready = !busy_q || (emit && at_last);
	assign load       = item_valid && item_ready;

	// Select the word and register-select level for the current byte.
	always_comb begin
		case (idx_q[3:1])
			SLOT_X_INDEX: begin
				word    = PANEL_REG_GRAM_X;
				word_rs = RS_INDEX;
			end
			SLOT_X_DATA: begin
				word    = GRAM_X_START;
				word_rs = RS_DATA;
			end
			SLOT_Y_INDEX: begin
				word    = PANEL_REG_GRAM_Y;
				word_rs = RS_INDEX;
			end
			SLOT_Y_DATA: begin
				word    = item_q.row;
				word_rs = RS_DATA;
			end
			SLOT_GRAM_INDEX: begin
				word    = PANEL_REG_GRAM_DATA;
				word_rs = RS_INDEX;
			end
			SLOT_COLOUR: begin
				word    = item_q.colour;
				word_rs = RS_DATA;
			end
			default: begin
				word    = item_q.colour;
				word_rs = RS_DATA;
			end
		endcase
	end

	// Sequencer: the high byte of each word goes first.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			idx_q  <= BYTE_FIRST;
		end else begin
			if (load) begin
				busy_q <= 1'b1;
				idx_q  <= item.row_start ? BYTE_FIRST : BYTE_COLOUR_HI;
			end else if (emit) begin
				if (at_last) begin
					busy_q <= 1'b0;
				end else begin
					idx_q <= idx_q + 4'd1;
				end
			end
		end
	end

	// Request payload held for the whole sequence.
	always_ff @(posedge clk) begin
		if (load) begin
			item_q <= item;
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= busy_q;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (emit) begin
			byte_q <= idx_q[0] ? word[7:0] : word[15:8];
			rs_q   <= word_rs;
			last_q <= at_last;
			done_q <= at_last && item_q.frame_end;
		end
	end

	assign out_valid      = out_valid_q;
	assign out_byte       = byte_q;
	assign out_rs         = rs_q;
	assign out_last       = last_q;
	assign out_frame_done = done_q;

	`ASSERT_CLK(a_done_on_last, clk, arst_n, out_valid_q && done_q |-> last_q, "frame end off pixel end")
	`ASSERT_CLK(a_last_is_data, clk, arst_n, out_valid_q && last_q |-> rs_q == RS_DATA, "pixel end not data byte")
	`ASSERT_CLK(a_mid_row_skip, clk, arst_n, load && !item.row_start |=> idx_q == BYTE_COLOUR_HI, "mid-row pixel sent header")

endmodule

// File: hdl/lcd_frame_bus_writer_unit.sv
// Top level of the LCD frame bus writer: input register, frame counters, configuration.
// Depends on lcdfw_pkg, lcdfw_byte_ser and assert_macros.svh.
//
// Takes one pixel per request as 8-bit red, green and blue, packs it to RGB565 and writes a
// frame to a TFT panel over an 8-bit parallel bus, one byte per output request, rows from the
// last row up to row 0. The first pixel of each row sends twelve bytes (register 0x20 = 0,
// register 0x21 = row, register 0x22 = pixel); other pixels send two, high byte first.
// tuser[0] is the register-select level, tlast marks a pixel's final byte and tuser[1] marks
// the frame's final byte. The output serialiser sends one byte per cycle while m_axis_tready
// stays high; an input register lets the next pixel wait while the current one is sent.
// Writing either size register (0 acts as 1, above MAX_SIDE acts as MAX_SIDE) restarts the
// frame; write only while the block is idle. Reset gives 240 x 320.
`include "assert_macros.svh"

module lcd_frame_bus_writer_unit
	import lcdfw_pkg::*;
#(
	parameter int MAX_SIDE = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	// Pixel input.
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [23:0] s_axis_tdata,   // red [7:0], green [15:8], blue [23:16]
	// Bus byte output.
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [7:0]  m_axis_tdata,   // bus_byte [7:0]
	output logic        m_axis_tlast,
	output logic [1:0]  m_axis_tuser,   // register_select [0], frame_done [1]
	// Configuration writes.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [10:0] cfg_data
);

	localparam int CNT_W = (MAX_SIDE > 2) ? $clog2(MAX_SIDE) : 1;

	// Last index of a side after clamping the register value to 1 .. MAX_SIDE.
	function automatic logic [CNT_W-1:0] side_last(input logic [10:0] v);
		int e;
		e = int'(v);
		if (e < 1) begin
			e = 1;
		end else if (e > MAX_SIDE) begin
			e = MAX_SIDE;
		end
		return CNT_W'(e - 1);
	endfunction

	logic [CNT_W-1:0] w_last_q;
	logic [CNT_W-1:0] h_last_q;
	logic [CNT_W-1:0] col_cnt_q;
	logic [CNT_W-1:0] row_cnt_q;
	logic             s1_valid_q;
	pix_item_t        item_s1;

	logic             in_acc;
	logic             cfg_acc;
	logic             ser_ready;
	logic             row_end;
	logic [31:0]      row_ext;
	logic [7:0]       red;
	logic [7:0]       green;
	logic [7:0]       blue;
	pix_item_t        item_d;

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid && cfg_ready;

	// The input register takes a request when empty or when it hands on now.
	assign s_axis_tready = !s1_valid_q || ser_ready;
	assign in_acc        = s_axis_tvalid && s_axis_tready;

	assign red     = s_axis_tdata[7:0];
	assign green   = s_axis_tdata[15:8];
	assign blue    = s_axis_tdata[23:16];
	assign row_end = (col_cnt_q == w_last_q);
	assign row_ext = 32'(row_cnt_q);

	// Pack the colour and note where the pixel sits in the frame.
	always_comb begin
		item_d.colour    = {red[7:3], green[7:2], blue[7:3]};
		item_d.row       = row_ext[15:0];
		item_d.row_start = (col_cnt_q == '0);
		item_d.frame_end = row_end && (row_cnt_q == '0);
	end

	// Size registers, held as last indexes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_last_q <= side_last(11'd240);
			h_last_q <= side_last(11'd320);
		end else if (cfg_acc) begin
			case (cfg_index)
				CFG_FRAME_WIDTH:  w_last_q <= side_last(cfg_data);
				CFG_FRAME_HEIGHT: h_last_q <= side_last(cfg_data);
				default: ;
			endcase
		end
	end

	// Column and row counters; a size write restarts the frame.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= side_last(11'd320);
		end else if (cfg_acc) begin
			case (cfg_index)
				CFG_FRAME_WIDTH: begin
					col_cnt_q <= '0;
					row_cnt_q <= h_last_q;
				end
				CFG_FRAME_HEIGHT: begin
					col_cnt_q <= '0;
					row_cnt_q <= side_last(cfg_data);
				end
				default: ;
			endcase
		end else if (in_acc) begin
			if (row_end) begin
				col_cnt_q <= '0;
				row_cnt_q <= (row_cnt_q == '0) ? h_last_q : row_cnt_q - CNT_W'(1);
			end else begin
				col_cnt_q <= col_cnt_q + CNT_W'(1);
			end
		end
	end

	// Input register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_q <= s_axis_tvalid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= item_d;
		end
	end

	lcdfw_byte_ser u_ser (
		.clk            (clk),
		.arst_n         (arst_n),
		.item_valid     (s1_valid_q),
		.item_ready     (ser_ready),
		.item           (item_s1),
		.out_valid      (m_axis_tvalid),
		.out_ready      (m_axis_tready),
		.out_byte       (m_axis_tdata),
		.out_rs         (m_axis_tuser[0]),
		.out_last       (m_axis_tlast),
		.out_frame_done (m_axis_tuser[1])
	);

	`ASSERT_CLK(a_accept_fills_s1, clk, arst_n, in_acc |=> s1_valid_q, "accepted pixel lost")
	`ASSERT_CLK(a_cfg_restarts, clk, arst_n, cfg_acc && (cfg_index == CFG_FRAME_WIDTH || cfg_index == CFG_FRAME_HEIGHT) |=> col_cnt_q == '0, "size write did not restart frame")
	`ASSERT_CLK(a_row_wrap, clk, arst_n, in_acc && !cfg_acc && row_end |=> col_cnt_q == '0, "column did not wrap at row end")

endmodule
